>>> rtl/tspc_pkg.sv
// ----------------------------------------------------------------------------
// tspc_pkg
// shared widths, constants and types of the two-point temperature calibration
// ----------------------------------------------------------------------------
package tspc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CODE_BITS   = 10;
    localparam int DIFF_BITS   = 16;
    localparam int SPAN_BITS   = 23;
    localparam int CS_BITS     = 22;
    localparam int FS_BITS     = 23;
    localparam int OFF_BITS    = 36;
    localparam int ACC_BITS    = 40;
    localparam int OUT_BITS    = 18;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_BITS    = 5;
    localparam int MPLR_BITS   = (SAMPLE_BITS > CODE_BITS) ? SAMPLE_BITS : CODE_BITS;

    localparam logic [SPAN_BITS-1:0] CEL_SPAN_Q16 = SPAN_BITS'(3604480);
    localparam logic [SPAN_BITS-1:0] FAH_SPAN_Q16 = SPAN_BITS'(6488064);

    localparam logic signed [ACC_BITS-1:0] CEL_AT30_Q16  = ACC_BITS'(1998848);
    localparam logic signed [ACC_BITS-1:0] FAH_AT30_Q16  = ACC_BITS'(5668864);
    localparam logic signed [ACC_BITS-1:0] KEL_SHIFT_Q16 = ACC_BITS'(17901158);

    localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(2 ** (OUT_BITS - 1) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = -ACC_BITS'(2 ** (OUT_BITS - 1));

    typedef enum logic [1:0] {
        CFG_CAL_PRESENT = 2'd0,
        CFG_CODE_AT_30C = 2'd1,
        CFG_CODE_AT_85C = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic sub;
        logic en_b;
    } t_alu_ctl;

endpackage

>>> rtl/temp_sensor_two_point_calibration_core.sv
// ----------------------------------------------------------------------------
// temp_sensor_two_point_calibration_core
// raw sensor code to celsius, kelvin and fahrenheit by two-point calibration
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------------
//  sample    | in        | i_valid / o_ready    | i_sample
//  result    | out       | o_valid / i_ready    | o_celsius o_kelvin o_fahrenheit
//            |           |                      | o_uncalibrated
//  config    | in        | i_cfg_we             | i_cfg_idx i_cfg_data
//
//  one transaction at a time through a shared add / subtract unit
//  cached scales: a sample runs the two scale multiplies and the kelvin add
//  first sample after a config write or reset first runs the two restoring
//  divides and the two offset multiplies to compute the scales and offsets,
//  or only zeroes them when calibration is absent or the code difference is zero
//  a result waits in the output register; the next transaction is accepted
//  meanwhile and holds in its last state until the output register is free
// ----------------------------------------------------------------------------
module temp_sensor_two_point_calibration_core
    import tspc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [OUT_BITS-1:0] o_celsius,
    output logic signed [OUT_BITS-1:0] o_kelvin,
    output logic signed [OUT_BITS-1:0] o_fahrenheit,
    output logic                       o_uncalibrated,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [CODE_BITS-1:0]       i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_PREP  = 10'b00_0000_0010,
        S_DIVC  = 10'b00_0000_0100,
        S_DIVF  = 10'b00_0000_1000,
        S_OFFC  = 10'b00_0001_0000,
        S_OFFF  = 10'b00_0010_0000,
        S_MULC  = 10'b00_0100_0000,
        S_MULF  = 10'b00_1000_0000,
        S_KELV  = 10'b01_0000_0000,
        S_WRITE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic                 r_cur;
    logic                 r_cal;
    logic [CODE_BITS-1:0] r_code30;
    logic [CODE_BITS-1:0] r_code85;
    logic                 r_out_valid;

    logic [SAMPLE_BITS-1:0]     r_sample;
    logic [DIFF_BITS:0]         r_rem;
    logic [SPAN_BITS-1:0]       r_quo;
    logic signed [ACC_BITS-1:0] r_acc;
    logic [ACC_BITS-1:0]        r_mcand;
    logic [MPLR_BITS-1:0]       r_mplr;
    logic [CNT_BITS-1:0]        r_cnt;
    logic [CS_BITS-1:0]         r_cs;
    logic [FS_BITS-1:0]         r_fs;
    logic signed [OFF_BITS-1:0] r_co;
    logic signed [OFF_BITS-1:0] r_fo;
    logic signed [ACC_BITS-1:0] r_cel;
    logic signed [ACC_BITS-1:0] r_kel;
    logic signed [OUT_BITS-1:0] r_celsius;
    logic signed [OUT_BITS-1:0] r_kelvin;
    logic signed [OUT_BITS-1:0] r_fahrenheit;
    logic                       r_uncal_out;

    logic                       w_accept;
    logic                       w_load;
    logic                       w_last;
    logic                       w_uncal;
    logic [DIFF_BITS-1:0]       w_diff;
    logic                       w_div_bit;
    logic [DIFF_BITS:0]         w_rem_sh;
    logic [SPAN_BITS-1:0]       n_quo;
    logic signed [ACC_BITS-1:0] w_a;
    logic signed [ACC_BITS-1:0] w_b;
    t_alu_ctl                   w_ctl;
    logic signed [ACC_BITS-1:0] w_sum;
    logic                       w_neg;
    logic signed [OUT_BITS-1:0] w_sat_c;
    logic signed [OUT_BITS-1:0] w_sat_k;
    logic signed [OUT_BITS-1:0] w_sat_f;

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_celsius      = r_celsius;
    assign o_kelvin       = r_kelvin;
    assign o_fahrenheit   = r_fahrenheit;
    assign o_uncalibrated = r_uncal_out;

    assign w_accept  = i_valid && o_ready;
    assign w_load    = (r_state == S_WRITE) && (!r_out_valid || i_ready);
    assign w_last    = (r_cnt == '0);
    assign w_diff    = DIFF_BITS'(r_code85) - DIFF_BITS'(r_code30);
    assign w_uncal   = !r_cal || (r_code85 == r_code30);
    assign w_div_bit = (r_state == S_DIVC) ? CEL_SPAN_Q16[r_cnt] : FAH_SPAN_Q16[r_cnt];
    assign w_rem_sh  = {r_rem[DIFF_BITS-1:0], w_div_bit};
    assign n_quo     = {r_quo[SPAN_BITS-2:0], !w_neg};

    // shared unit operand select
    always_comb begin
        w_a   = r_acc;
        w_b   = $signed(r_mcand);
        w_ctl = '{sub: 1'b0, en_b: 1'b0};
        unique case (r_state)
            S_DIVC, S_DIVF: begin
                w_a   = $signed(ACC_BITS'(w_rem_sh));
                w_b   = $signed(ACC_BITS'(w_diff));
                w_ctl = '{sub: 1'b1, en_b: 1'b1};
            end
            S_OFFC, S_OFFF: begin
                w_ctl = '{sub: 1'b1, en_b: r_mplr[0]};
            end
            S_MULC, S_MULF: begin
                w_ctl = '{sub: 1'b0, en_b: r_mplr[0]};
            end
            S_KELV: begin
                w_a   = r_cel;
                w_b   = KEL_SHIFT_Q16;
                w_ctl = '{sub: 1'b0, en_b: 1'b1};
            end
            default: begin
                w_ctl = '{sub: 1'b0, en_b: 1'b0};
            end
        endcase
    end

    tspc_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_ctl (w_ctl),
        .o_sum (w_sum),
        .o_neg (w_neg)
    );

    tspc_sat u_sat_c (.i_val(r_cel), .o_val(w_sat_c));
    tspc_sat u_sat_k (.i_val(r_kel), .o_val(w_sat_k));
    tspc_sat u_sat_f (.i_val(r_acc), .o_val(w_sat_f));

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_PREP;
            end
            S_PREP: begin
                if (r_cur) begin
                    n_state = S_MULC;
                end else if (!w_uncal) begin
                    n_state = S_DIVC;
                end
            end
            S_DIVC: begin
                if (w_last) n_state = S_DIVF;
            end
            S_DIVF: begin
                if (w_last) n_state = S_OFFC;
            end
            S_OFFC: begin
                if (w_last) n_state = S_OFFF;
            end
            S_OFFF: begin
                if (w_last) n_state = S_PREP;
            end
            S_MULC: begin
                if (w_last) n_state = S_MULF;
            end
            S_MULF: begin
                if (w_last) n_state = S_KELV;
            end
            S_KELV: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= 1'b0;
            r_cal       <= 1'b0;
            r_code30    <= '0;
            r_code85    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_PREP) && !r_cur && w_uncal) begin
                r_cur <= 1'b1;
            end
            if ((r_state == S_OFFF) && w_last) begin
                r_cur <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAL_PRESENT: begin
                        r_cal <= i_cfg_data[0];
                        r_cur <= 1'b0;
                    end
                    CFG_CODE_AT_30C: begin
                        r_code30 <= i_cfg_data;
                        r_cur    <= 1'b0;
                    end
                    CFG_CODE_AT_85C: begin
                        r_code85 <= i_cfg_data;
                        r_cur    <= 1'b0;
                    end
                    default: begin
                        r_cur <= r_cur;
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) r_sample <= i_sample;
            end
            S_PREP: begin
                if (r_cur) begin
                    r_acc   <= ACC_BITS'(r_co);
                    r_mcand <= ACC_BITS'(r_cs);
                    r_mplr  <= MPLR_BITS'(r_sample);
                    r_cnt   <= CNT_BITS'(SAMPLE_BITS - 1);
                end else if (w_uncal) begin
                    r_cs <= '0;
                    r_fs <= '0;
                    r_co <= '0;
                    r_fo <= '0;
                end else begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CNT_BITS'(SPAN_BITS - 1);
                end
            end
            S_DIVC, S_DIVF: begin
                r_rem <= w_neg ? w_rem_sh : w_sum[DIFF_BITS:0];
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (w_last) begin
                    r_rem <= '0;
                    r_quo <= '0;
                    if (r_state == S_DIVC) begin
                        r_cs  <= n_quo[CS_BITS-1:0];
                        r_cnt <= CNT_BITS'(SPAN_BITS - 1);
                    end else begin
                        r_fs    <= n_quo[FS_BITS-1:0];
                        r_acc   <= CEL_AT30_Q16;
                        r_mcand <= ACC_BITS'(r_cs);
                        r_mplr  <= MPLR_BITS'(r_code30);
                        r_cnt   <= CNT_BITS'(CODE_BITS - 1);
                    end
                end
            end
            S_OFFC, S_OFFF, S_MULC, S_MULF: begin
                r_acc   <= w_sum;
                r_mcand <= {r_mcand[ACC_BITS-2:0], 1'b0};
                r_mplr  <= r_mplr >> 1;
                r_cnt   <= r_cnt - 1'b1;
                if (w_last) begin
                    if (r_state == S_OFFC) begin
                        r_co    <= w_sum[OFF_BITS-1:0];
                        r_acc   <= FAH_AT30_Q16;
                        r_mcand <= ACC_BITS'(r_fs);
                        r_mplr  <= MPLR_BITS'(r_code30);
                        r_cnt   <= CNT_BITS'(CODE_BITS - 1);
                    end else if (r_state == S_OFFF) begin
                        r_fo <= w_sum[OFF_BITS-1:0];
                    end else if (r_state == S_MULC) begin
                        r_cel   <= w_sum;
                        r_acc   <= ACC_BITS'(r_fo);
                        r_mcand <= ACC_BITS'(r_fs);
                        r_mplr  <= MPLR_BITS'(r_sample);
                        r_cnt   <= CNT_BITS'(SAMPLE_BITS - 1);
                    end
                end
            end
            S_KELV: begin
                r_kel <= w_sum;
            end
            S_WRITE: begin
                if (w_load) begin
                    r_celsius    <= w_sat_c;
                    r_kelvin     <= w_sat_k;
                    r_fahrenheit <= w_sat_f;
                    r_uncal_out  <= w_uncal;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

>>> rtl/tspc_alu.sv
// ----------------------------------------------------------------------------
// tspc_alu
// shared add / subtract unit used by the divide and multiply sequences
// ----------------------------------------------------------------------------
module tspc_alu
    import tspc_pkg::*;
(
    input  logic signed [ACC_BITS-1:0] i_a,
    input  logic signed [ACC_BITS-1:0] i_b,
    input  t_alu_ctl                   i_ctl,
    output logic signed [ACC_BITS-1:0] o_sum,
    output logic                       o_neg
);

    logic signed [ACC_BITS-1:0] w_b;

    always_comb begin
        w_b = i_ctl.en_b ? i_b : '0;
        if (i_ctl.sub) begin
            o_sum = i_a - w_b;
        end else begin
            o_sum = i_a + w_b;
        end
        o_neg = o_sum[ACC_BITS-1];
    end

endmodule

>>> rtl/tspc_sat.sv
// ----------------------------------------------------------------------------
// tspc_sat
// floor of a signed 24.16 value to whole degrees, saturated to the result width
// ----------------------------------------------------------------------------
module tspc_sat
    import tspc_pkg::*;
(
    input  logic signed [ACC_BITS-1:0] i_val,
    output logic signed [OUT_BITS-1:0] o_val
);

    logic signed [ACC_BITS-1:0] w_int;

    always_comb begin
        w_int = i_val >>> FRAC_BITS;
        if (w_int > SAT_HI) begin
            o_val = {1'b0, {(OUT_BITS-1){1'b1}}};
        end else if (w_int < SAT_LO) begin
            o_val = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            o_val = w_int[OUT_BITS-1:0];
        end
    end

endmodule
